[design/assert_macros.svh]
// assertion macros included by the controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

[design/mpc_pkg.sv]
// package with shared types, constants and helper functions of the colorizer
`default_nettype none
package mpc_pkg;
	localparam int SizeW  = 13;
	localparam int CountW = 16;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 16;

	// register indexes of the configuration port
	localparam logic [CfgIdxW-1:0] RegWidth  = 2'd0;
	localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;
	localparam logic [CfgIdxW-1:0] RegLimit  = 2'd2;

	localparam logic [SizeW-1:0]  ResetWidth  = 13'd512;
	localparam logic [SizeW-1:0]  ResetHeight = 13'd512;
	localparam logic [CountW-1:0] ResetLimit  = 16'd1536;

	localparam logic [7:0] HuePeriod = 8'd200;
	// floor(v/200) as (v*Recip200)>>RecipShift, exact for v below 2^16
	localparam logic [16:0] Recip200 = 17'd83887;
	localparam int RecipShift = 24;

	// divider select
	localparam logic DivReal = 1'b0;
	localparam logic DivImag = 1'b1;

	typedef struct packed {
		logic load_in;
		logic div_start;
		logic div_sel;
		logic cr_load;
		logic ci_load;
		logic mul;
		logic upd;
		logic col1;
		logic col2;
		logic col3;
		logic out_load;
	} mpc_cmd_t;

	typedef struct packed {
		logic div_done;
		logic degen;
		logic lim_hit;
		logic esc_a;
		logic esc_b;
	} mpc_stat_t;

	// quotient by the hue period through a reciprocal product
	function automatic logic [8:0] div200(input logic [15:0] v);
		logic [32:0] p;
		p = {17'd0, v} * {16'd0, Recip200};
		return p[RecipShift+8:RecipShift];
	endfunction
endpackage
`default_nettype wire

[design/mpc_div.sv]
// restoring divider, one quotient bit per cycle
`default_nettype none
module mpc_div #(
	parameter int NW = 40,
	parameter int DW = 13
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quo
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   shifted;
	logic          ge;
	logic [DW:0]   diff;

	// one restoring step
	always_comb begin
		shifted = {rem_q, num_q[NW-1]};
		ge      = shifted >= {1'b0, den_q};
		diff    = shifted - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = num_q;
endmodule
`default_nettype wire

[design/mpc_dp.sv]
// datapath: config registers, coordinate mapping, iteration and colour
`default_nettype none
module mpc_dp import mpc_pkg::*; #(
	parameter int FRAC_BITS  = 26,
	parameter int COORD_BITS = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mpc_cmd_t              cmd,
	output mpc_stat_t                  st,
	input  wire logic                  cfg_we,
	input  wire logic [CfgIdxW-1:0]    cfg_index,
	input  wire logic [CfgDataW-1:0]   cfg_data,
	input  wire logic [COORD_BITS-1:0] pixel_x,
	input  wire logic [COORD_BITS-1:0] pixel_y,
	output logic [7:0]                 red,
	output logic [7:0]                 green,
	output logic [7:0]                 blue,
	output logic                       inside_set,
	output logic [CountW-1:0]          iteration_count
);
	localparam int NW = COORD_BITS + FRAC_BITS + 2;
	localparam int ZW = NW + 2;
	localparam int MW = FRAC_BITS + 1;
	localparam int PW = FRAC_BITS + 2;
	localparam logic [ZW-1:0] TwoOne    = ZW'(2) << FRAC_BITS;
	localparam logic [ZW-1:0] ThreeHalf = ZW'(3) << (FRAC_BITS - 1);

	logic [SizeW-1:0]      width_q, height_q;
	logic [CountW-1:0]     limit_q;
	logic [COORD_BITS-1:0] x_q, y_q;
	logic [ZW-1:0]         cr_q, ci_q, zr_q, zi_q;
	logic [CountW-1:0]     count_q;
	logic [PW-1:0]         zr2_q, zi2_q, zri_q;
	logic                  sgn_q;
	logic [8:0]            q1_q;
	logic [2:0]            seg_q;
	logic [7:0]            f_q;
	logic [7:0]            r_q, g_q, b_q;
	logic                  in_q;

	logic [NW-1:0]         div_num;
	logic [SizeW-1:0]      div_den;
	logic                  div_done;
	logic [NW-1:0]         div_quo;
	logic [COORD_BITS+1:0] y3;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ResetWidth;
			height_q <= ResetHeight;
			limit_q  <= ResetLimit;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegWidth:  width_q  <= cfg_data[SizeW-1:0];
				RegHeight: height_q <= cfg_data[SizeW-1:0];
				RegLimit:  limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// divider operands: x*4 or y*3 in fixed point over size-1
	always_comb begin
		y3      = ({2'b00, y_q} << 1) + {2'b00, y_q};
		div_num = (cmd.div_sel == DivImag) ? {y3, {FRAC_BITS{1'b0}}}
		                                   : {x_q, {(FRAC_BITS + 2){1'b0}}};
		div_den = (cmd.div_sel == DivImag) ? height_q - 1'b1 : width_q - 1'b1;
	end

	mpc_div #(.NW(NW), .DW(SizeW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// magnitudes and escape tests
	logic [ZW-1:0]   zr_mag, zi_mag;
	logic [PW:0]     mag_sum;
	logic [2*MW-1:0] p_rr, p_ii, p_ri;
	logic [ZW-1:0]   dbl, zi_new, zr_new;
	always_comb begin
		zr_mag  = zr_q[ZW-1] ? -zr_q : zr_q;
		zi_mag  = zi_q[ZW-1] ? -zi_q : zi_q;
		p_rr    = zr_mag[MW-1:0] * zr_mag[MW-1:0];
		p_ii    = zi_mag[MW-1:0] * zi_mag[MW-1:0];
		p_ri    = zr_mag[MW-1:0] * zi_mag[MW-1:0];
		mag_sum = {1'b0, zr2_q} + {1'b0, zi2_q};
		dbl     = ZW'(zri_q) << 1;
		zi_new  = sgn_q ? ci_q - dbl : ci_q + dbl;
		zr_new  = ZW'(zr2_q) - ZW'(zi2_q) + cr_q;
	end

	assign st.div_done = div_done;
	assign st.degen    = (width_q < SizeW'(2)) || (height_q < SizeW'(2));
	assign st.lim_hit  = count_q >= limit_q;
	assign st.esc_a    = (|zr_mag[ZW-1:MW]) || (|zi_mag[ZW-1:MW]);
	assign st.esc_b    = mag_sum[PW];

	// colour helpers
	logic [7:0]  m;
	logic [10:0] t;
	logic [2:0]  seg;
	logic [10:0] fbase;
	logic [15:0] f255, g255;
	logic [8:0]  rise9, fall9;
	logic [7:0]  rise, fall;
	always_comb begin
		m = 8'(count_q - 16'(q1_q) * 16'(HuePeriod));
		t = ({3'b000, m} << 2) + ({3'b000, m} << 1);
		priority if (t >= 11'd1000) begin
			seg = 3'd5; fbase = 11'd1000;
		end else if (t >= 11'd800) begin
			seg = 3'd4; fbase = 11'd800;
		end else if (t >= 11'd600) begin
			seg = 3'd3; fbase = 11'd600;
		end else if (t >= 11'd400) begin
			seg = 3'd2; fbase = 11'd400;
		end else if (t >= 11'd200) begin
			seg = 3'd1; fbase = 11'd200;
		end else begin
			seg = 3'd0; fbase = 11'd0;
		end
		f255  = ({8'd0, f_q} << 8) - {8'd0, f_q};
		g255  = ({8'd0, HuePeriod - f_q} << 8) - {8'd0, HuePeriod - f_q};
		rise9 = div200(f255);
		fall9 = div200(g255);
		rise  = rise9[7:0];
		fall  = fall9[7:0];
	end

	// pixel, plane point and iteration registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_q <= pixel_x;
			y_q <= pixel_y;
		end
		if (cmd.cr_load) cr_q <= ZW'(div_quo) - TwoOne;
		if (cmd.ci_load) begin
			ci_q    <= ZW'(div_quo) - ThreeHalf;
			zr_q    <= '0;
			zi_q    <= '0;
			count_q <= '0;
		end
		if (cmd.mul) begin
			zr2_q <= p_rr[2*MW-1:FRAC_BITS];
			zi2_q <= p_ii[2*MW-1:FRAC_BITS];
			zri_q <= p_ri[2*MW-1:FRAC_BITS];
			sgn_q <= zr_q[ZW-1] ^ zi_q[ZW-1];
		end
		if (cmd.upd) begin
			zr_q    <= zr_new;
			zi_q    <= zi_new;
			count_q <= count_q + 1'b1;
		end
		if (cmd.col1) q1_q <= div200(count_q);
		if (cmd.col2) begin
			seg_q <= seg;
			f_q   <= 8'(t - fbase);
		end
		if (cmd.col3) begin
			in_q <= count_q == limit_q;
			if (count_q == limit_q) begin
				r_q <= 8'd0; g_q <= 8'd0; b_q <= 8'd0;
			end else begin
				unique case (seg_q)
					3'd0: begin r_q <= 8'd255; g_q <= rise;   b_q <= 8'd0;   end
					3'd1: begin r_q <= fall;   g_q <= 8'd255; b_q <= 8'd0;   end
					3'd2: begin r_q <= 8'd0;   g_q <= 8'd255; b_q <= rise;   end
					3'd3: begin r_q <= 8'd0;   g_q <= fall;   b_q <= 8'd255; end
					3'd4: begin r_q <= rise;   g_q <= 8'd0;   b_q <= 8'd255; end
					default: begin r_q <= 8'd255; g_q <= 8'd0; b_q <= fall; end
				endcase
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (st.degen) begin
				red <= 8'd0; green <= 8'd0; blue <= 8'd0;
				inside_set <= 1'b0;
				iteration_count <= '0;
			end else begin
				red <= r_q; green <= g_q; blue <= b_q;
				inside_set <= in_q;
				iteration_count <= count_q;
			end
		end
	end
endmodule
`default_nettype wire

[design/mpc_ctrl.sv]
// controller state machine sequencing mapping, iteration and colour
`default_nettype none
module mpc_ctrl import mpc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire mpc_stat_t st,
	output mpc_cmd_t       cmd
);
`include "assert_macros.svh"

	typedef enum logic [3:0] {
		IDLE, DIVR_GO, DIVR_WAIT, DIVI_GO, DIVI_WAIT,
		IT_A, IT_B, COL1, COL2, COL3, FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_xfer, out_free;

	assign in_ready  = state_q == IDLE;
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd = '0;
		cmd.load_in = in_xfer;
		unique case (state_q)
			DIVR_GO:   begin cmd.div_start = 1'b1; cmd.div_sel = DivReal; end
			DIVR_WAIT: begin cmd.div_sel = DivReal; cmd.cr_load = st.div_done; end
			DIVI_GO:   begin cmd.div_start = 1'b1; cmd.div_sel = DivImag; end
			DIVI_WAIT: begin cmd.div_sel = DivImag; cmd.ci_load = st.div_done; end
			IT_A:      cmd.mul = !st.lim_hit && !st.esc_a;
			IT_B:      cmd.upd = !st.esc_b;
			COL1:      cmd.col1 = 1'b1;
			COL2:      cmd.col2 = 1'b1;
			COL3:      cmd.col3 = 1'b1;
			FIN:       cmd.out_load = out_free;
			default: ;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// set when the result register loads, cleared on the output transfer
			priority if (state_q == FIN && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				IDLE:      if (in_xfer) state_q <= st.degen ? FIN : DIVR_GO;
				DIVR_GO:   state_q <= DIVR_WAIT;
				DIVR_WAIT: if (st.div_done) state_q <= DIVI_GO;
				DIVI_GO:   state_q <= DIVI_WAIT;
				DIVI_WAIT: if (st.div_done) state_q <= IT_A;
				IT_A:      state_q <= (st.lim_hit || st.esc_a) ? COL1 : IT_B;
				IT_B:      state_q <= st.esc_b ? COL1 : IT_A;
				COL1:      state_q <= COL2;
				COL2:      state_q <= COL3;
				COL3:      state_q <= FIN;
				FIN:       if (out_free) state_q <= IDLE;
				default:   state_q <= IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_no_overwrite, cmd.out_load, !out_valid_q || out_ready, "result overwritten")
	`ASSERT_CLK(a_one_step, !(cmd.mul && cmd.upd), "multiply and update together")
	`ASSERT_IMPL(a_div_done_wait, st.div_done, state_q == DIVR_WAIT || state_q == DIVI_WAIT, "divider finished unexpectedly")
endmodule
`default_nettype wire

[design/mandelbrot_pixel_colorizer.sv]
// top level of the mandelbrot escape-time pixel colorizer
// Usage: a pixel (pixel_x, pixel_y) is taken by an in_valid/in_ready transfer
// while the block is idle. The column and row are mapped onto the plane by two
// runs of a shared bit-serial divider, then z = z*z + c iterates, each
// iteration a multiply step and then an add and compare step. Colouring runs
// through the steps COL1, COL2 and COL3, and then the result register loads.
// One pixel is in work at a time. A degenerate size (width or height below 2)
// skips all work and goes straight to loading an all-zero result.
// The result sits in an output register held until the out_valid/out_ready
// transfer; a new pixel is taken while it waits, and a finished pixel waits in
// its last step while the receiver stalls. Configuration writes on
// cfg_valid/cfg_ready are always taken and must happen only while idle.
// Reset clears the control state and loads width 512, height 512, limit 1536.
`default_nettype none
module mandelbrot_pixel_colorizer import mpc_pkg::*; #(
	parameter int FRAC_BITS  = 26,
	parameter int COORD_BITS = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [COORD_BITS-1:0] pixel_x,
	input  wire logic [COORD_BITS-1:0] pixel_y,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 red,
	output logic [7:0]                 green,
	output logic [7:0]                 blue,
	output logic                       inside_set,
	output logic [CountW-1:0]          iteration_count,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CfgIdxW-1:0]    cfg_index,
	input  wire logic [CfgDataW-1:0]   cfg_data
);
	mpc_cmd_t  cmd;
	mpc_stat_t st;

	assign cfg_ready = 1'b1;

	mpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	mpc_dp #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.inside_set      (inside_set),
		.iteration_count (iteration_count)
	);
endmodule
`default_nettype wire
